// File: sv/bkck_pkg.sv
// Shared constants and types for the best-K cost keeper.
package bkck_pkg;

  localparam int MAX_KEEP = 16;
  localparam int SLOT_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int KEEP_W   = 5;
  localparam int EW       = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
  localparam int COST_W   = 32;
  localparam int TAG_W    = 16;
  localparam int MARGIN_W = 31;
  localparam int CFG_W    = 32;

  localparam logic REG_KEEP_COUNT    = 1'b0;
  localparam logic REG_ACCEPT_MARGIN = 1'b1;

  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic [TAG_W-1:0]         tag;
  } slot_t;

endpackage

// File: sv/best_k_cost_keeper.sv
// Top level of the best-K cost keeper: sequencer, slot memory and output register.
// An insert is checked against minus the margin on acceptance. A rejected or appended
// insert and an empty drain go straight to the output register. An insert into a full
// store scans every held slot through one comparator. A drain reads the slot memory one
// entry at a time (registered read, then output load). The input is stalled while an
// item is in work. A finished word waits in the output register, and the sequencer waits
// only when it has a new word and the register still holds one.
module best_k_cost_keeper (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 req_type,
  input  logic signed [bkck_pkg::COST_W-1:0]   cost,
  input  logic [bkck_pkg::TAG_W-1:0]           tag,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 accepted,
  output logic                                 evicted,
  output logic [bkck_pkg::TAG_W-1:0]           evicted_tag,
  output logic                                 entry_valid,
  output logic signed [bkck_pkg::COST_W-1:0]   out_cost,
  output logic [bkck_pkg::TAG_W-1:0]           out_tag,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [bkck_pkg::CFG_W-1:0]           cfg_data
);
  import bkck_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_DRD    = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;

  logic [2:0]               state;
  logic [KEEP_W-1:0]        keep_count;
  logic [MARGIN_W-1:0]      accept_margin;
  logic [CNT_W-1:0]         held;
  logic [CNT_W-1:0]         idx;
  logic signed [COST_W-1:0] cur_cost;
  logic [TAG_W-1:0]         cur_tag;
  logic                     r_acc;
  logic                     r_ev;
  logic [TAG_W-1:0]         r_evtag;
  logic                     cmp_vld;
  logic                     cmp_first;
  logic [SLOT_W-1:0]        cmp_idx;

  slot_t             mem [MAX_KEEP];
  slot_t             rd_q;
  slot_t             wr_data;
  logic [SLOT_W-1:0] wr_addr;
  logic              wr_en;

  slot_t             worst;
  logic [SLOT_W-1:0] worst_idx;

  logic [EW-1:0]         keep_ext;
  logic [EW-1:0]         eff_keep;
  logic                  has_room;
  logic signed [COST_W:0] neg_margin;
  logic signed [COST_W:0] margin_ext;
  logic                  reject;
  logic                  replace;
  logic                  issue;
  logic                  out_free;
  logic                  out_load;
  logic                  accept_in;
  logic                  last_ent;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && (state inside {S_EMIT, S_DWAIT});

  assign keep_ext = EW'(keep_count);
  assign eff_keep = (keep_count == '0) ? EW'(1) :
                    (keep_ext > EW'(MAX_KEEP)) ? EW'(MAX_KEEP) : keep_ext;
  assign has_room = EW'(held) < eff_keep;

  assign margin_ext = $signed({2'b00, accept_margin});
  assign neg_margin = -margin_ext;
  assign reject     = $signed({cost[COST_W-1], cost}) > neg_margin;
  assign replace    = ($signed({worst.cost[COST_W-1], worst.cost}) - margin_ext) >
                      $signed({cur_cost[COST_W-1], cur_cost});

  assign issue    = idx < held;
  assign last_ent = CNT_W'(idx + 1'b1) == held;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = held[SLOT_W-1:0];
    wr_data = '{cost: cost, tag: tag};
    if (state == S_IDLE && accept_in && !req_type && !reject && has_room) begin
      wr_en = 1'b1;
    end else if (state == S_DECIDE && replace) begin
      wr_en   = 1'b1;
      wr_addr = worst_idx;
      wr_data = '{cost: cur_cost, tag: cur_tag};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[idx[SLOT_W-1:0]];
  end

  bkck_worst u_worst (
    .clk       (clk),
    .en        (cmp_vld),
    .first     (cmp_first),
    .cand      (rd_q),
    .cand_idx  (cmp_idx),
    .worst     (worst),
    .worst_idx (worst_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count    <= KEEP_W'(16);
      accept_margin <= MARGIN_W'(66);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEEP_COUNT:    keep_count    <= cfg_data[KEEP_W-1:0];
        REG_ACCEPT_MARGIN: accept_margin <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      idx       <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept_in) begin
            cur_cost <= cost;
            cur_tag  <= tag;
            r_acc    <= !req_type && !reject && has_room;
            r_ev     <= 1'b0;
            r_evtag  <= '0;
            idx      <= '0;
            cmp_vld  <= 1'b0;
            if (req_type) begin
              state <= (held == '0) ? S_EMIT : S_DRD;
            end else if (reject) begin
              state <= S_EMIT;
            end else if (has_room) begin
              held  <= held + 1'b1;
              state <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_vld   <= issue;
          cmp_first <= (idx == '0);
          cmp_idx   <= idx[SLOT_W-1:0];
          if (issue) begin
            idx <= idx + 1'b1;
          end else if (!cmp_vld) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          r_acc   <= replace;
          r_ev    <= replace;
          r_evtag <= replace ? worst.tag : '0;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            accepted    <= r_acc;
            evicted     <= r_ev;
            evicted_tag <= r_evtag;
            entry_valid <= 1'b0;
            out_cost    <= '0;
            out_tag     <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_DRD: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            accepted    <= 1'b0;
            evicted     <= 1'b0;
            evicted_tag <= '0;
            entry_valid <= 1'b1;
            out_cost    <= rd_q.cost;
            out_tag     <= rd_q.tag;
            last        <= last_ent;
            if (last_ent) begin
              held  <= '0;
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/bkck_worst.sv
// Shared comparator that tracks the worst (largest cost) slot during a scan.
module bkck_worst (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        first,
  input  bkck_pkg::slot_t             cand,
  input  logic [bkck_pkg::SLOT_W-1:0] cand_idx,
  output bkck_pkg::slot_t             worst,
  output logic [bkck_pkg::SLOT_W-1:0] worst_idx
);
  import bkck_pkg::*;

  logic larger;

  assign larger = cand.cost > worst.cost;

  always_ff @(posedge clk) begin
    if (en && (first || larger)) begin
      worst     <= cand;
      worst_idx <= cand_idx;
    end
  end

endmodule

// File: sv/bkck_chk.sv
// Port-level checker for the best-K cost keeper and its bind to the top level.
module bkck_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 accepted,
  input logic                                 evicted,
  input logic [bkck_pkg::TAG_W-1:0]           evicted_tag,
  input logic                                 entry_valid,
  input logic signed [bkck_pkg::COST_W-1:0]   out_cost,
  input logic                                 last
);
  import bkck_pkg::*;

  a_drain_no_insert: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_valid |-> !accepted && !evicted)
    else $error("Drain word carries insert flags.");

  a_evict_implies_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> accepted)
    else $error("Eviction reported without acceptance.");

  a_no_evict_zero_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_tag == '0)
    else $error("Evicted tag is nonzero without an eviction.");

  a_single_word_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !entry_valid |-> last)
    else $error("Insert or empty drain word is not marked last.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_cost))
    else $error("Stalled output word changed.");

endmodule

bind best_k_cost_keeper bkck_chk u_bkck_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .accepted    (accepted),
  .evicted     (evicted),
  .evicted_tag (evicted_tag),
  .entry_valid (entry_valid),
  .out_cost    (out_cost),
  .last        (last)
);

// File: bench/tb_best_k_cost_keeper.sv
// Self-checking testbench for best_k_cost_keeper, with a scoreboard that tracks the kept costs.
`timescale 1ns / 100ps

module tb_best_k_cost_keeper;
  import bkck_pkg::*;

  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 40;
  localparam int LONG_HOLD       = 300;
  localparam int IDLE_LIMIT      = 3000;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 23;

  typedef struct packed {
    logic                     accepted;
    logic                     evicted;
    logic [TAG_W-1:0]         evicted_tag;
    logic                     entry_valid;
    logic signed [COST_W-1:0] out_cost;
    logic [TAG_W-1:0]         out_tag;
    logic                     last;
  } kept_word_t;

  class kept_cost_tracker;
    logic signed [COST_W-1:0] slot_cost [MAX_KEEP];
    logic [TAG_W-1:0]         slot_tag [MAX_KEEP];
    int                       held;
    logic [KEEP_W-1:0]        keep_count;
    logic [MARGIN_W-1:0]      margin;
    kept_word_t               pending_words [$];
    int                       fails;

    function new();
      held = 0;
      keep_count = KEEP_W'(16);
      margin = MARGIN_W'(66);
      fails = 0;
    endfunction

    function void queue_word(kept_word_t w);
      pending_words = {pending_words, w};
    endfunction

    function void apply_config(logic idx, logic [CFG_W-1:0] data);
      if (idx == REG_KEEP_COUNT) begin
        keep_count = data[KEEP_W-1:0];
      end else if (idx == REG_ACCEPT_MARGIN) begin
        margin = data[MARGIN_W-1:0];
      end
    endfunction

    function void note_request(logic rq, logic signed [COST_W-1:0] cost_in,
                               logic [TAG_W-1:0] tag_in);
      kept_word_t w;
      longint     c;
      longint     m;
      longint     wc;
      int         worst;
      int         lim;
      w = '0;
      w.last = 1'b1;
      c = cost_in;
      m = margin;
      lim = keep_count;
      if (lim < 1) lim = 1;
      if (lim > MAX_KEEP) lim = MAX_KEEP;
      if (rq) begin
        if (held == 0) begin
          queue_word(w);
        end else begin
          for (int i = 0; i < held; i++) begin
            w = '0;
            w.entry_valid = 1'b1;
            w.out_cost = slot_cost[i];
            w.out_tag = slot_tag[i];
            w.last = (i == held - 1);
            queue_word(w);
          end
          held = 0;
        end
      end else if (c > -m) begin
        queue_word(w);
      end else if (held < lim) begin
        slot_cost[held] = cost_in;
        slot_tag[held] = tag_in;
        held++;
        w.accepted = 1'b1;
        queue_word(w);
      end else begin
        worst = 0;
        wc = slot_cost[0];
        for (int i = 1; i < held; i++) begin
          if (longint'(slot_cost[i]) > wc) begin
            wc = slot_cost[i];
            worst = i;
          end
        end
        if (wc - m > c) begin
          w.accepted = 1'b1;
          w.evicted = 1'b1;
          w.evicted_tag = slot_tag[worst];
          slot_cost[worst] = cost_in;
          slot_tag[worst] = tag_in;
        end
        queue_word(w);
      end
    endfunction

    function string show(kept_word_t w);
      return $sformatf("acc=%0b ev=%0b etag=%h ent=%0b cost=%0d tag=%h last=%0b",
                       w.accepted, w.evicted, w.evicted_tag, w.entry_valid,
                       w.out_cost, w.out_tag, w.last);
    endfunction

    function void check_word(kept_word_t got);
      kept_word_t want;
      if (pending_words.size() == 0) begin
        fails++;
        if (fails <= 10) $display("ERROR: unexpected word %s", show(got));
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10) begin
            $display("ERROR: expected %s", show(want));
            $display("       actual   %s", show(got));
          end
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     req_type;
  logic signed [COST_W-1:0] cost;
  logic [TAG_W-1:0]         tag;
  logic                     out_valid;
  logic                     out_stall;
  logic                     accepted;
  logic                     evicted;
  logic [TAG_W-1:0]         evicted_tag;
  logic                     entry_valid;
  logic signed [COST_W-1:0] out_cost;
  logic [TAG_W-1:0]         out_tag;
  logic                     last;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  kept_cost_tracker         tracker;
  bit                       hold_requested;
  int                       quiet_cycles;
  logic signed [COST_W-1:0] last_cost;

  best_k_cost_keeper dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .cost        (cost),
    .tag         (tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .accepted    (accepted),
    .evicted     (evicted),
    .evicted_tag (evicted_tag),
    .entry_valid (entry_valid),
    .out_cost    (out_cost),
    .out_tag     (out_tag),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_request(req_type, cost, tag);
      if (out_valid && !out_stall) begin
        tracker.check_word({accepted, evicted, evicted_tag, entry_valid,
                            out_cost, out_tag, last});
      end
      if (cfg_valid && cfg_ready) tracker.apply_config(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int mode;
    int len;
    forever begin
      if (hold_requested) begin
        hold_requested = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(5, 40);
        repeat (len) begin
          out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 99) < mode * 25);
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(logic rq, logic signed [COST_W-1:0] cv, logic [TAG_W-1:0] tv);
    in_valid <= 1'b1;
    req_type <= rq;
    cost <= cv;
    tag <= tv;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_config(logic idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [KEEP_W-1:0] keep, logic [MARGIN_W-1:0] margin);
    settle();
    write_config(REG_KEEP_COUNT, {(CFG_W-KEEP_W)'($urandom()), keep});
    write_config(REG_ACCEPT_MARGIN, {1'($urandom()), margin});
    cfg_valid <= 1'b0;
  endtask

  task automatic insert(logic signed [COST_W-1:0] cv, logic [TAG_W-1:0] tv);
    send_item(1'b0, cv, tv);
  endtask

  task automatic drain();
    send_item(1'b1, COST_W'($urandom()), TAG_W'($urandom()));
  endtask

  task automatic pick_item(output logic rq, output logic signed [COST_W-1:0] cv,
                           output logic [TAG_W-1:0] tv);
    int     roll;
    longint base;
    longint span;
    longint step;
    roll = $urandom_range(0, 99);
    rq = (roll < 9);
    tv = TAG_W'($urandom());
    if (roll < 20) begin
      cv = COST_W'($urandom());
    end else if (roll < 30) begin
      cv = last_cost;
    end else begin
      span = 3 * longint'(tracker.margin) + 2000;
      if (span > 64'sh7fff_ffff) span = 64'sh7fff_ffff;
      step = $urandom_range(0, 32'(span));
      base = -longint'(tracker.margin) - step;
      if ($urandom_range(0, 7) == 0) base = base + longint'($urandom_range(0, 40));
      if (base < -64'sh8000_0000) base = -64'sh8000_0000;
      cv = base[COST_W-1:0];
    end
    last_cost = cv;
  endtask

  task automatic random_items(int count);
    int                       burst;
    int                       gap;
    logic                     rq;
    logic signed [COST_W-1:0] cv;
    logic [TAG_W-1:0]         tv;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      pick_item(rq, cv, tv);
      send_item(rq, cv, tv);
    end
  endtask

  initial begin
    tracker = new();
    hold_requested = 1'b0;
    last_cost = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= 1'b0;
    cost <= '0;
    tag <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_KEEP_COUNT;
    cfg_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default settings: empty drain, the margin boundary and the cost extremes.
    drain();
    insert(-32'sd66, 16'h0001);
    insert(-32'sd65, 16'h0002);
    insert(32'sh7fff_ffff, 16'hffff);
    insert(32'sh8000_0000, 16'hffff);
    insert(-32'sd1000, 16'h0000);
    drain();

    // Two slots with zero margin: ties, replacement and a rejected equal cost.
    configure(5'd2, 31'd0);
    insert(32'sd0, 16'h0010);
    insert(32'sd0, 16'h0011);
    insert(-32'sd5, 16'h0012);
    insert(32'sd0, 16'h0013);
    insert(-32'sd1, 16'h0014);

    // Keep count below the number held: the store stays full with both entries.
    configure(5'd1, 31'd0);
    insert(-32'sd3, 16'h0015);
    drain();

    // Zero keep count and the largest margin.
    configure(5'd0, 31'h7fff_ffff);
    insert(32'sh8000_0001, 16'h0020);
    insert(32'sh8000_0000, 16'h0021);
    insert(32'sh8000_0002, 16'h0022);

    configure(5'd31, 31'd1);
    insert(-32'sd2, 16'h0030);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: configure(5'd16, 31'($urandom_range(0, 200)));
        1: configure(5'd1, 31'd0);
        2: configure(5'($urandom_range(4, 16)), 31'($urandom_range(0, 5000)));
        3: configure(5'd0, 31'($urandom_range(0, 100000)));
        4: configure(5'd31, 31'h7fff_ffff);
        5: configure(5'($urandom()), 31'($urandom()));
        default: configure(5'($urandom_range(1, 16)), 31'($urandom_range(0, 300)));
      endcase
      if (phase == 2) hold_requested = 1'b1;
      random_items(ITEMS_PER_PHASE);
    end

    settle();
    if (tracker.fails == 0 && tracker.pending_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
